// ===== hdl/ktg_pkg.sv =====
// Package for the keypad tone generator: widths, register indexes, controller
// states, the key frequency table and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package ktg_pkg;

	localparam int KEY_COUNT  = 16;
	localparam int TIMER_BITS = 13;
	localparam int KEY_W      = 16;
	localparam int NOTE_W     = 5;
	localparam int SCAN_W     = 16;
	localparam int DUR_W      = 24;
	localparam int NUM_W      = 16;
	localparam int FREQ_W     = 11;
	localparam int DIV_CNT_W  = 4;
	localparam int PROD_W     = NUM_W + 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_W      = 8;

	localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_COUNT) - 64'd1);
	localparam logic [TIMER_BITS-1:0] HALF_MAX = {TIMER_BITS{1'b1}};
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_TICKS     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_NUMERATOR = 4'd3;

	localparam logic [SCAN_W-1:0] RST_SCAN_INTERVAL  = 16'd500;
	localparam logic [SCAN_W-1:0] RST_DEBOUNCE_TICKS = 16'd20000;
	localparam logic [DUR_W-1:0]  RST_NOTE_TICKS     = 24'd200000;
	localparam logic [NUM_W-1:0]  RST_TONE_NUMERATOR = 16'd46083;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic [SCAN_W-1:0] scan_interval;
		logic [SCAN_W-1:0] debounce_ticks;
		logic [DUR_W-1:0]  note_ticks;
		logic [NUM_W-1:0]  tone_numerator;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic div_load;
		logic div_step;
		logic half_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic note_start;
		logic div_last;
	} dp_status_t;

	// key frequency in Hz, key numbers 1..16
	function automatic logic [FREQ_W-1:0] key_freq(input logic [NOTE_W-1:0] key);
		logic [FREQ_W-1:0] f;
		case (4'(key - 5'd1))
			4'd0:    f = 11'd525;
			4'd1:    f = 11'd494;
			4'd2:    f = 11'd440;
			4'd3:    f = 11'd392;
			4'd4:    f = 11'd784;
			4'd5:    f = 11'd698;
			4'd6:    f = 11'd659;
			4'd7:    f = 11'd587;
			4'd8:    f = 11'd1174;
			4'd9:    f = 11'd1046;
			4'd10:   f = 11'd987;
			4'd11:   f = 11'd880;
			4'd12:   f = 11'd1760;
			4'd13:   f = 11'd1567;
			4'd14:   f = 11'd1396;
			default: f = 11'd1318;
		endcase
		return f;
	endfunction

	// highest pressed key number, 0 when none
	function automatic logic [NOTE_W-1:0] highest_key(input logic [KEY_W-1:0] keys);
		logic [NOTE_W-1:0] k;
		k = '0;
		for (int i = 0; i < KEY_W; i++) begin
			if (keys[i]) begin
				k = NOTE_W'(i + 1);
			end
		end
		return k;
	endfunction

endpackage

// ===== hdl/keypad_tone_generator_unit.sv =====
// Top level of the keypad tone generator: stream ports, configuration port,
// controller and datapath. Depends on ktg_pkg, ktg_cfg_regs, ktg_ctrl, ktg_datapath.
`timescale 1ns / 1ps

// Each request on the slave stream is one timer tick carrying the 16-key
// pressed map and yields one result on the master stream: speaker level,
// playing flag and the sounding key. A tick that confirms a key and starts
// a note keeps the controller busy while the half period is worked out by
// a 16-step serial divider and then scaled and saturated. The result sits
// in an output register, so once the controller is idle the next tick is
// taken in the cycle its predecessor's result leaves. Configuration writes
// are always ready and belong between ticks.

module keypad_tone_generator_unit
	import ktg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [KEY_W-1:0]      s_tdata,   // [15:0] keys_down
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // [0] speaker, [1] playing, [6:2] note_key
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	ktg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ktg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ktg_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.keys_in  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== hdl/ktg_cfg_regs.sv =====
// Configuration register bank of the keypad tone generator.
// Depends on ktg_pkg.
`timescale 1ns / 1ps

module ktg_cfg_regs
	import ktg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// write the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_interval  <= RST_SCAN_INTERVAL;
			cfg_q.debounce_ticks <= RST_DEBOUNCE_TICKS;
			cfg_q.note_ticks     <= RST_NOTE_TICKS;
			cfg_q.tone_numerator <= RST_TONE_NUMERATOR;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCAN_INTERVAL:  cfg_q.scan_interval  <= cfg_data[SCAN_W-1:0];
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[SCAN_W-1:0];
				REG_NOTE_TICKS:     cfg_q.note_ticks     <= cfg_data[DUR_W-1:0];
				REG_TONE_NUMERATOR: cfg_q.tone_numerator <= cfg_data[NUM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/ktg_ctrl.sv =====
// Controller of the keypad tone generator: takes ticks and sequences the
// serial half-period divide at note start. Depends on ktg_pkg.
`timescale 1ns / 1ps

module ktg_ctrl
	import ktg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	logic        accept;

	assign accept = (state_q == ST_IDLE) && s_tvalid && status.out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && status.note_start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// commands and handshake
	always_comb begin
		s_tready      = 1'b0;
		cmd.tick      = 1'b0;
		cmd.div_load  = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.half_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready     = status.out_free;
				cmd.tick     = accept;
				cmd.div_load = accept && status.note_start;
			end
			ST_DIV:  cmd.div_step  = 1'b1;
			ST_FIN:  cmd.half_load = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/ktg_datapath.sv =====
// Datapath of the keypad tone generator: scan/debounce timers, note timers,
// serial divider for the half period and the result register.
// Depends on ktg_pkg.
`timescale 1ns / 1ps

module ktg_datapath
	import ktg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	input  logic [KEY_W-1:0] keys_in,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [OUT_W-1:0] m_tdata
);

	logic [SCAN_W-1:0]     scan_count_q;
	logic                  debouncing_q;
	logic [SCAN_W-1:0]     debounce_count_q;
	logic [NOTE_W-1:0]     pending_key_q;
	logic                  note_active_q;
	logic [DUR_W-1:0]      duration_count_q;
	logic [TIMER_BITS-1:0] half_period_q;
	logic [TIMER_BITS-1:0] tone_count_q;
	logic                  speaker_q;

	logic [NUM_W-1:0]      dvd_q;
	logic [FREQ_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;

	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	logic [KEY_W-1:0]      keys;
	logic [DUR_W-1:0]      dur_inc;
	logic [TIMER_BITS-1:0] tone_inc;
	logic [SCAN_W-1:0]     deb_inc;
	logic [SCAN_W-1:0]     scan_inc;
	logic                  note_end;
	logic                  active_mid;
	logic                  deb_done;
	logic                  start;

	logic [SCAN_W-1:0]     scan_count_d;
	logic                  debouncing_d;
	logic [SCAN_W-1:0]     debounce_count_d;
	logic [NOTE_W-1:0]     pending_key_d;
	logic                  note_active_d;
	logic [DUR_W-1:0]      duration_count_d;
	logic [TIMER_BITS-1:0] tone_count_d;
	logic                  speaker_d;

	logic [FREQ_W:0]       trial;
	logic                  qbit;
	logic [PROD_W-1:0]     prod;
	logic [TIMER_BITS-1:0] half_d;

	assign keys       = keys_in & KEY_MASK;
	assign dur_inc    = duration_count_q + 1'b1;
	assign tone_inc   = tone_count_q + 1'b1;
	assign deb_inc    = debounce_count_q + 1'b1;
	assign scan_inc   = scan_count_q + 1'b1;
	assign note_end   = note_active_q && (dur_inc >= cfg.note_ticks);
	assign active_mid = note_active_q && !note_end;
	assign deb_done   = debouncing_q && (deb_inc >= cfg.debounce_ticks);
	assign start      = deb_done && (keys != '0) && !active_mid;

	// advance the note, then either the debounce or the scan
	always_comb begin
		scan_count_d     = scan_count_q;
		debouncing_d     = debouncing_q;
		debounce_count_d = debounce_count_q;
		pending_key_d    = pending_key_q;
		note_active_d    = note_active_q;
		duration_count_d = duration_count_q;
		tone_count_d     = tone_count_q;
		speaker_d        = speaker_q;

		if (note_active_q) begin
			duration_count_d = dur_inc;
			tone_count_d     = tone_inc;
			if (tone_inc >= half_period_q) begin
				tone_count_d = '0;
				speaker_d    = ~speaker_q;
			end
			if (note_end) begin
				note_active_d    = 1'b0;
				duration_count_d = '0;
				tone_count_d     = '0;
				speaker_d        = 1'b1;
			end
		end

		if (debouncing_q) begin
			debounce_count_d = deb_inc;
			if (deb_done) begin
				debouncing_d     = 1'b0;
				debounce_count_d = '0;
				scan_count_d     = '0;
				if (start) begin
					pending_key_d    = highest_key(keys);
					note_active_d    = 1'b1;
					duration_count_d = '0;
					tone_count_d     = '0;
				end
			end
		end else begin
			scan_count_d = scan_inc;
			if (scan_inc >= cfg.scan_interval) begin
				scan_count_d = '0;
				if (keys != '0) begin
					debouncing_d     = 1'b1;
					debounce_count_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_count_q     <= '0;
			debouncing_q     <= 1'b0;
			debounce_count_q <= '0;
			pending_key_q    <= '0;
			note_active_q    <= 1'b0;
			duration_count_q <= '0;
			tone_count_q     <= '0;
			speaker_q        <= 1'b1;
		end else if (cmd.tick) begin
			scan_count_q     <= scan_count_d;
			debouncing_q     <= debouncing_d;
			debounce_count_q <= debounce_count_d;
			pending_key_q    <= pending_key_d;
			note_active_q    <= note_active_d;
			duration_count_q <= duration_count_d;
			tone_count_q     <= tone_count_d;
			speaker_q        <= speaker_d;
		end
	end

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign qbit  = (trial >= {1'b0, key_freq(pending_key_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q <= cfg.tone_numerator;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[NUM_W-2:0], qbit};
			if (qbit) begin
				rem_q <= FREQ_W'(trial - {1'b0, key_freq(pending_key_q)});
			end else begin
				rem_q <= trial[FREQ_W-1:0];
			end
		end
	end

	// scale the quotient by ten and saturate, forcing a zero product to one
	assign prod = ({4'b0, dvd_q} << 3) + ({4'b0, dvd_q} << 1);

	always_comb begin
		if (prod > PROD_W'(HALF_MAX)) begin
			half_d = HALF_MAX;
		end else if (prod == '0) begin
			half_d = TIMER_BITS'(1);
		end else begin
			half_d = prod[TIMER_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= '0;
		end else if (cmd.half_load) begin
			half_period_q <= half_d;
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			out_data_q <= {1'b0,
				(note_active_d ? pending_key_d : NOTE_W'(0)),
				note_active_d, speaker_d};
		end
	end

	assign m_tvalid          = out_valid_q;
	assign m_tdata           = out_data_q;
	assign status.out_free   = !out_valid_q || m_tready;
	assign status.note_start = start;
	assign status.div_last   = (div_cnt_q == DIV_LAST);

endmodule
